// ===== hdl/imf_pkg.sv =====
// ----------------------------------------------------------------------------
// imf_pkg
// Shared types and constants for the image median filter.
// ----------------------------------------------------------------------------
package imf_pkg;

  localparam int unsigned CfgW = 11;
  localparam int unsigned RowLimit = 1024;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RADIUS = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_GATHER = 2'd1,
    ST_SORT   = 2'd2,
    ST_OUT    = 2'd3
  } state_e;

  // Position and frame flag of the result held in the output register.
  typedef struct packed {
    logic [9:0]  col;
    logic [9:0]  row;
    logic        last;
  } job_t;

endpackage

// ===== hdl/image_median_filter_top.sv =====
// ----------------------------------------------------------------------------
// image_median_filter_top
// Streaming square-window median filter over a raster grayscale image.
// ----------------------------------------------------------------------------
// Usage: pixels enter on the input channel (func_i = 0) in raster order; once
// the window around a position is complete its median leaves on the output
// channel with its column, row and a frame-last flag. After the last pixel,
// drain transfers (func_i = 1) push out the remaining results, one each.
// Registers (APB): 0 width, 1 height, 2 radius; a write to any of them restarts the frame.
// Timing: one transfer at a time. A transfer that yields a result gathers
// the window through the line-store read port, then runs an odd-even
// transposition sort in the window registers, then loads the output
// register. Throughput is set by the single read port of the line store and
// the sort: a new input is taken only after the previous result is loaded.
// Reset: positions clear and registers go to 1024, 1024, 1. The line store
// needs no clearing; only entries written in the current frame are read.
// Stall: a waiting result holds the output register; no new input is taken
// until it has been transferred.
// ----------------------------------------------------------------------------
module image_median_filter_top
  import imf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_RADIUS = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [7:0]  pixel_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  pixel_out_o,
  output logic [9:0]  out_col_o,
  output logic [9:0]  out_row_o,
  output logic        frame_last_o
);

  localparam int unsigned Depth = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned Side = 2 * MAX_RADIUS + 1;
  localparam int unsigned Taps = Side * Side;
  localparam int unsigned TW = $clog2(Taps + 1);
  localparam int unsigned LW = 22;

  logic [CfgW-1:0] width_q, height_q;
  logic [1:0]      radius_q;
  logic            cfg_we;
  logic [10:0]     w_eff, h_eff;
  logic [1:0]      r_eff;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:  prdata = {21'd0, width_q};
      REG_HEIGHT: prdata = {21'd0, height_q};
      REG_RADIUS: prdata = {30'd0, radius_q};
      default:    prdata = 32'd0;
    endcase
  end

  always_comb begin
    if (width_q == '0) begin
      w_eff = 11'd1;
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = 11'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = 11'd1;
    end else if (32'(height_q) > RowLimit) begin
      h_eff = 11'(RowLimit);
    end else begin
      h_eff = height_q;
    end
    if (radius_q == '0) begin
      r_eff = 2'd1;
    end else if (32'(radius_q) > MAX_RADIUS) begin
      r_eff = 2'(MAX_RADIUS);
    end else begin
      r_eff = radius_q;
    end
  end

  // Position state; linear indices kept as running counters.
  state_e          state_q, state_d;
  logic [9:0]      in_col_q, in_row_q, em_col_q, em_row_q;
  logic [LW-1:0]   in_lin_q;
  logic [AW-1:0]   wptr_q;
  logic            drain_q;
  logic            cfg_restart_q;

  logic [7:0]      win_q [Taps];
  logic [TW-1:0]   tap_q, ntaps;
  logic [2:0]      dx_q, dy_q, side;
  logic            rd_pend_q;
  logic [TW-1:0]   rd_idx_q;
  logic [AW-1:0]   raddr;
  logic [7:0]      rdata;
  logic [TW-1:0]   pass_q;
  logic [7:0]      res_q;
  logic            out_valid_q;
  job_t            job_q;

  logic in_xfer, out_xfer, is_pix, emits;
  logic [LW-1:0] thresh;
  logic last_em;

  assign side = {r_eff, 1'b1};
  assign ntaps = TW'(side) * TW'(side);
  assign thresh = LW'(r_eff) * LW'(w_eff) + LW'(r_eff);
  assign in_ready_o = (state_q == ST_IDLE) && !out_valid_q;
  assign in_xfer = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_q && out_ready_i;
  assign is_pix = !func_i;
  assign emits = is_pix ? (in_lin_q >= thresh && !drain_q) ||
                          (drain_q && 22'd0 >= thresh) : drain_q;
  assign last_em = (11'(em_row_q) == h_eff - 11'd1) && (11'(em_col_q) == w_eff - 11'd1);

  // Window tap address: clamp row/col, then step back from the write pointer.
  logic signed [11:0] ty, tx;
  logic [10:0] cy, cx;
  logic [LW-1:0] lin, back;
  always_comb begin
    ty = $signed({2'b0, em_row_q}) + $signed({9'b0, dy_q}) - $signed({10'b0, r_eff});
    tx = $signed({2'b0, em_col_q}) + $signed({9'b0, dx_q}) - $signed({10'b0, r_eff});
    if (ty < 0) cy = '0;
    else if (ty > $signed({1'b0, h_eff - 11'd1})) cy = h_eff - 11'd1;
    else cy = ty[10:0];
    if (tx < 0) cx = '0;
    else if (tx > $signed({1'b0, w_eff - 11'd1})) cx = w_eff - 11'd1;
    else cx = tx[10:0];
    lin = LW'(cy) * LW'(w_eff) + LW'(cx);
    // taps lie between 1 and Depth entries behind the next write position
    back = in_lin_q - lin;
    raddr = (wptr_q >= AW'(back)) ? wptr_q - AW'(back)
                                  : wptr_q + AW'(Depth) - AW'(back);
  end

  imf_ram #(.Width(8), .Depth(Depth)) u_line (
    .clk_i  (clk_i),
    .we_i   (in_xfer && is_pix),
    .waddr_i((drain_q) ? '0 : wptr_q),
    .wdata_i(pixel_in_i),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_xfer && emits) state_d = ST_GATHER;
      ST_GATHER: if (rd_pend_q && rd_idx_q == ntaps - 1'b1) state_d = ST_SORT;
      ST_SORT:   if (pass_q == ntaps) state_d = ST_OUT;
      ST_OUT:    state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      width_q <= 11'd1024; height_q <= 11'd1024; radius_q <= 2'd1;
      in_col_q <= '0; in_row_q <= '0; em_col_q <= '0; em_row_q <= '0;
      in_lin_q <= '0; wptr_q <= '0; drain_q <= 1'b0; cfg_restart_q <= 1'b0;
      out_valid_q <= 1'b0; tap_q <= '0; dx_q <= '0; dy_q <= '0;
      rd_pend_q <= 1'b0; rd_idx_q <= '0; pass_q <= '0;
      job_q <= '0;
    end else begin
      state_q <= state_d;
      cfg_restart_q <= 1'b0;
      if (cfg_we) begin
        case (paddr[3:2])
          REG_WIDTH:  begin width_q <= pwdata[10:0]; cfg_restart_q <= 1'b1; end
          REG_HEIGHT: begin height_q <= pwdata[10:0]; cfg_restart_q <= 1'b1; end
          REG_RADIUS: begin radius_q <= pwdata[1:0]; cfg_restart_q <= 1'b1; end
          default: ;
        endcase
      end
      if (cfg_restart_q) begin
        in_col_q <= '0; in_row_q <= '0; em_col_q <= '0; em_row_q <= '0;
        in_lin_q <= '0; wptr_q <= '0; drain_q <= 1'b0;
      end
      if (out_xfer) out_valid_q <= 1'b0;
      if (in_xfer && is_pix) begin
        // pixel while drain pending restarts at position zero
        if (drain_q) begin
          em_col_q <= '0; em_row_q <= '0;
          in_lin_q <= LW'(1); wptr_q <= AW'(1);
          drain_q <= 1'b0;
          if (w_eff == 11'd1) begin
            in_col_q <= '0;
            if (h_eff == 11'd1) begin in_row_q <= '0; drain_q <= 1'b1; end
            else in_row_q <= 10'd1;
          end else begin
            in_col_q <= 10'd1; in_row_q <= '0;
          end
        end else begin
          in_lin_q <= in_lin_q + 1'b1;
          wptr_q <= (32'(wptr_q) == Depth - 1) ? '0 : wptr_q + 1'b1;
          if (11'(in_col_q) + 11'd1 >= w_eff) begin
            in_col_q <= '0;
            if (11'(in_row_q) + 11'd1 >= h_eff) begin
              in_row_q <= '0; drain_q <= 1'b1;
            end else begin
              in_row_q <= in_row_q + 1'b1;
            end
          end else begin
            in_col_q <= in_col_q + 1'b1;
          end
        end
      end
      if (in_xfer && emits) begin
        tap_q <= '0; dx_q <= '0; dy_q <= '0; rd_pend_q <= 1'b0; pass_q <= '0;
      end
      if (state_q == ST_GATHER) begin
        rd_pend_q <= (tap_q < ntaps);
        rd_idx_q <= tap_q;
        if (rd_pend_q) win_q[rd_idx_q] <= rdata;
        if (tap_q < ntaps) begin
          tap_q <= tap_q + 1'b1;
          if (dx_q == side - 3'd1) begin dx_q <= '0; dy_q <= dy_q + 1'b1; end
          else dx_q <= dx_q + 1'b1;
        end
      end
      if (state_q == ST_SORT) begin
        pass_q <= pass_q + 1'b1;
        for (int i = 0; i + 1 < Taps; i++) begin
          if ((i % 2) == int'(pass_q[0]) && TW'(i + 1) < ntaps &&
              win_q[i] > win_q[i + 1]) begin
            win_q[i] <= win_q[i + 1];
            win_q[i + 1] <= win_q[i];
          end
        end
      end
      if (state_q == ST_OUT) begin
        res_q <= win_q[ntaps >> 1];
        job_q.col <= em_col_q; job_q.row <= em_row_q; job_q.last <= last_em;
        out_valid_q <= 1'b1;
        if (last_em) begin
          em_col_q <= '0; em_row_q <= '0; drain_q <= 1'b0;
          in_lin_q <= '0; wptr_q <= '0;
        end else if (11'(em_col_q) + 11'd1 >= w_eff) begin
          em_col_q <= '0;
          em_row_q <= (11'(em_row_q) + 11'd1 >= h_eff) ? '0 : em_row_q + 1'b1;
        end else begin
          em_col_q <= em_col_q + 1'b1;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = res_q;
  assign out_col_o = job_q.col;
  assign out_row_o = job_q.row;
  assign frame_last_o = job_q.last;

endmodule

// ===== hdl/imf_ram.sv =====
// ----------------------------------------------------------------------------
// imf_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module imf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 6151
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== verif/image_median_filter_top_tb.sv =====
// ----------------------------------------------------------------------------
// image_median_filter_top_tb
// Self-checking bench for the streaming square-window median filter: random
// image sizes and radii are programmed over APB, frames and drain transfers
// are streamed with random gaps and output stalls, and every result is
// compared against a median predictor with edge replication.
// ----------------------------------------------------------------------------
module image_median_filter_top_tb;
  import imf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StoreDepth = 6151;
  localparam int unsigned MaxW = 1024;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned SettleCycles = 120;

  typedef struct {
    logic [7:0] pix;
    logic [9:0] col;
    logic [9:0] row;
    logic       last;
  } median_res_t;

  class median_scoreboard;
    logic [10:0] width_reg, height_reg;
    logic [1:0]  radius_reg;
    logic [7:0]  store [StoreDepth];
    int unsigned in_col, in_row, emit_col, emit_row;
    bit          drain_pending;
    median_res_t expected_q[$];
    int unsigned errors;

    function new();
      width_reg = 11'd1024;
      height_reg = 11'd1024;
      radius_reg = 2'd1;
      restart();
    endfunction

    function void restart();
      in_col = 0; in_row = 0; emit_col = 0; emit_row = 0;
      drain_pending = 0;
    endfunction

    function int unsigned eff_w();
      if (width_reg == 0) return 1;
      return (width_reg > MaxW) ? MaxW : width_reg;
    endfunction

    function int unsigned eff_h();
      if (height_reg == 0) return 1;
      return (height_reg > RowLimit) ? RowLimit : height_reg;
    endfunction

    function int unsigned eff_r();
      return (radius_reg == 0) ? 1 : radius_reg;
    endfunction

    function void write_reg(reg_idx_e idx, logic [31:0] val);
      case (idx)
        REG_WIDTH:  width_reg = val[10:0];
        REG_HEIGHT: height_reg = val[10:0];
        default:    radius_reg = val[1:0];
      endcase
      restart();
    endfunction

    function void emit_result(int unsigned w, int unsigned h, int unsigned r);
      median_res_t res;
      logic [7:0]  taps[$];
      int          y, x;
      res.last = (emit_row == h - 1) && (emit_col == w - 1);
      for (int dy = -int'(r); dy <= int'(r); dy++) begin
        y = int'(emit_row) + dy;
        y = (y < 0) ? 0 : ((y > int'(h) - 1) ? int'(h) - 1 : y);
        for (int dx = -int'(r); dx <= int'(r); dx++) begin
          x = int'(emit_col) + dx;
          x = (x < 0) ? 0 : ((x > int'(w) - 1) ? int'(w) - 1 : x);
          taps.push_back(store[(y * w + x) % StoreDepth]);
        end
      end
      taps.sort();
      res.pix = taps[taps.size() / 2];
      res.col = emit_col[9:0];
      res.row = emit_row[9:0];
      expected_q.push_back(res);
      if (res.last) begin
        emit_col = 0; emit_row = 0; drain_pending = 0;
      end else begin
        emit_col++;
        if (emit_col >= w) begin
          emit_col = 0;
          emit_row++;
          if (emit_row >= h) emit_row = 0;
        end
      end
    endfunction

    // returns 1 unless the transfer was an ignored drain
    function bit note_input(bit func, logic [7:0] pix);
      int unsigned w, h, r, p;
      w = eff_w(); h = eff_h(); r = eff_r();
      if (func) begin
        if (!drain_pending) return 0;
        emit_result(w, h, r);
        return 1;
      end
      if (drain_pending) restart();
      p = in_row * w + in_col;
      store[p % StoreDepth] = pix;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
        if (in_row >= h) begin
          in_row = 0;
          drain_pending = 1;
        end
      end
      if (p >= r * w + r) emit_result(w, h, r);
      return 1;
    endfunction

    function void check(median_res_t got);
      median_res_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: pix=%0d col=%0d row=%0d last=%0b",
                   got.pix, got.col, got.row, got.last);
        return;
      end
      want = expected_q.pop_front();
      if (got.pix !== want.pix || got.col !== want.col || got.row !== want.row ||
          got.last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp pix=%0d col=%0d row=%0d last=%0b, got pix=%0d col=%0d row=%0d last=%0b",
                   want.pix, want.col, want.row, want.last,
                   got.pix, got.col, got.row, got.last);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        func_i = 1'b0;
  logic [7:0]  pixel_in_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  pixel_out_o;
  logic [9:0]  out_col_o, out_row_o;
  logic        frame_last_o;

  median_scoreboard sb = new();
  int unsigned used_items;
  int unsigned stall_cnt;
  bit          quiet;
  bit          out_hs;
  median_res_t out_snap;

  image_median_filter_top dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= quiet || ($urandom_range(0, 99) >= 31);
    if (out_hs) sb.check(out_snap);
  end

  // pre-edge snapshot of the output channel; also drives the watchdog
  always @(negedge clk_i) begin
    out_hs = out_valid_o && out_ready_i;
    out_snap.pix = pixel_out_o;
    out_snap.col = out_col_o;
    out_snap.row = out_row_o;
    out_snap.last = frame_last_o;
    if (out_hs || (in_valid_i && in_ready_o) || psel || !rst_ni) stall_cnt = 0;
    else stall_cnt++;
    if (stall_cnt >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send(bit func, logic [7:0] pix);
    while (!quiet && $urandom_range(0, 99) < 31) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= func;
    pixel_in_i <= pix;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    if (sb.note_input(func, pix)) used_items++;
    quiet = (used_items >= 900) && (used_items < 1200);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_access(reg_idx_e idx, bit wr, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= 4'(idx) << 2;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (!wr) begin
      if (prdata !== val) begin
        sb.errors++;
        if (sb.errors <= 10)
          $display("register %s read: exp %0h got %0h", idx.name(), val, prdata);
      end
    end
    @(posedge clk_i);
    if (wr) sb.write_reg(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(logic [10:0] w, logic [10:0] h, logic [1:0] r);
    wait_idle();
    apb_access(REG_WIDTH, 1'b1, 32'(w));
    apb_access(REG_HEIGHT, 1'b1, 32'(h));
    apb_access(REG_RADIUS, 1'b1, 32'(r));
    apb_access(REG_WIDTH, 1'b0, 32'(w));
    apb_access(REG_HEIGHT, 1'b0, 32'(h));
    apb_access(REG_RADIUS, 1'b0, 32'(r));
  endtask

  // kind 0: whole frame and full drain; 1: random length up to a whole frame; 2: partial drain
  task automatic run_frame(int kind);
    int unsigned n, need, cnt, dr;
    bit          binary;
    n = sb.eff_w() * sb.eff_h();
    need = sb.eff_r() * sb.eff_w() + sb.eff_r();
    need = (need > n) ? n : need;
    cnt = (kind == 1) ? $urandom_range(1, n) : n;
    binary = ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < cnt; i++)
      send(1'b0, binary ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                        : 8'($urandom_range(0, 255)));
    case (kind)
      0:       dr = need + $urandom_range(0, 1);
      1:       dr = $urandom_range(0, 2);
      default: dr = (need > 0) ? $urandom_range(0, need - 1) : 0;
    endcase
    for (int unsigned i = 0; i < dr; i++) send(1'b1, 8'($urandom));
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_access(REG_WIDTH, 1'b0, 32'd1024);
    apb_access(REG_HEIGHT, 1'b0, 32'd1024);
    apb_access(REG_RADIUS, 1'b0, 32'd1);
    send(1'b1, 8'h00);
    for (int i = 0; i < 12; i++) send(1'b0, (i % 2) ? 8'hFF : 8'h00);

    configure(11'd3, 11'd3, 2'd1);    run_frame(0);
    configure(11'd1, 11'd1, 2'd1);    run_frame(0);
    configure(11'd0, 11'd0, 2'd0);    run_frame(0);
    configure(11'd2, 11'd2, 2'd3);    run_frame(0);
    configure(11'd5, 11'd4, 2'd3);    run_frame(0); run_frame(2); run_frame(0);
    configure(11'd7, 11'd5, 2'd2);    run_frame(1); run_frame(0);
    configure(11'd1, 11'd2047, 2'd1); run_frame(0);

    while (used_items < 2000) begin
      if ($urandom_range(0, 9) == 0)
        configure(11'($urandom_range(0, 16)), 11'($urandom_range(0, 12)),
                  2'($urandom_range(0, 3)));
      else
        configure(11'($urandom_range(1, 12)), 11'($urandom_range(1, 8)),
                  2'($urandom_range(1, 3)));
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 9))
          0:       run_frame(1);
          1:       run_frame(2);
          default: run_frame(0);
        endcase
      end
    end
    wait_idle();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
